// ===== rtl/bcpc_pkg.sv =====
// Shared types and constants of the block-cyclic preceding count block.
package bcpc_pkg;

  // Internal index arithmetic width; the result is masked to at most this many bits.
  localparam int IndexBits = 32;
  localparam int NumWidth  = 31;
  localparam int DivWidth  = 32;
  localparam int SizeWidth = 16;
  localparam int DivSteps  = DivWidth;

  localparam logic [NumWidth-1:0] ResultMask = (IndexBits >= NumWidth) ?
      {NumWidth{1'b1}} : NumWidth'((64'd1 << IndexBits) - 64'd1);

  // Register indexes on the configuration port.
  localparam logic [2:0] RegFirstBlock = 3'd0;
  localparam logic [2:0] RegBlock      = 3'd1;
  localparam logic [2:0] RegProcCount  = 3'd2;
  localparam logic [2:0] RegSource     = 3'd3;
  localparam logic [2:0] RegMyProc     = 3'd4;

  // Effective configuration: sizes of zero already read as one.
  typedef struct packed {
    logic [SizeWidth-1:0] inb;
    logic [SizeWidth-1:0] nb;
    logic [SizeWidth-1:0] np;
    logic [SizeWidth-1:0] src;
    logic [SizeWidth-1:0] me;
    logic                 rep;
  } cfg_t;

  // Per-item context carried alongside the divider pipelines.
  typedef struct packed {
    logic [NumWidth-1:0]  n;
    logic [NumWidth-1:0]  idx;
    logic [NumWidth-1:0]  past;
    logic                 zero;
    logic                 ge;
    logic                 early;
    logic [SizeWidth-1:0] me;
    logic [SizeWidth-1:0] src;
    logic [SizeWidth-1:0] hops;
    logic [DivWidth-1:0]  inb;
  } ctx_t;

endpackage

// ===== rtl/bcpc_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
module bcpc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcpc_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [30:0]       run_length_i,
  input  logic [30:0]       start_index_i,
  output logic              item_valid_o,
  input  logic              item_pop_i,
  output bcpc_pkg::ctx_t    item_o
);

  bcpc_pkg::ctx_t ent_q [2];
  bcpc_pkg::ctx_t cls;
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push, pop;

  always_comb begin
    cls       = '0;
    cls.n     = run_length_i;
    cls.idx   = start_index_i;
    cls.zero  = cfg_i.rep || (cfg_i.np == 16'd1);
    cls.ge    = start_index_i >= 31'(cfg_i.inb);
    cls.past  = start_index_i - 31'(cfg_i.inb);
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = ent_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/bcpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with item context.
module bcpc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       dividend_i,
  input  logic [15:0]       divisor_i,
  input  bcpc_pkg::ctx_t    ctx_i,
  output logic              valid_o,
  output logic [31:0]       quot_o,
  output logic [15:0]       rem_o,
  output bcpc_pkg::ctx_t    ctx_o
);

  localparam int Steps = bcpc_pkg::DivSteps;

  logic [Steps:0]   vld_q;
  logic [31:0]      num_q [Steps+1];
  logic [15:0]      rem_q [Steps+1];
  bcpc_pkg::ctx_t   ctx_q [Steps+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= dividend_i;
      rem_q[0] <= '0;
      ctx_q[0] <= ctx_i;
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [16:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_q[s], num_q[s][31]};
      ge    = trial >= {1'b0, divisor_i};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= ge ? 16'(trial - {1'b0, divisor_i}) : trial[15:0];
        num_q[s+1] <= {num_q[s][30:0], ge};
        ctx_q[s+1] <= ctx_q[s];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign quot_o  = num_q[Steps];
  assign rem_o   = rem_q[Steps];
  assign ctx_o   = ctx_q[Steps];

endmodule

// ===== rtl/bcpc_back.sv =====
// Back end: chain of dividers and the final count arithmetic.
module bcpc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcpc_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  output logic              item_pop_o,
  input  bcpc_pkg::ctx_t    item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [30:0]       preceding_count_o
);

  logic en;

  logic           d0_vld, d1_vld, d2_vld, d3_vld, d4_vld;
  logic [31:0]    d0_q, d1_q, d2_q, d3_q, d4_q;
  logic [15:0]    d0_r, d1_r, d2_r, d3_r, d4_r;
  bcpc_pkg::ctx_t d0_ctx, d1_ctx, d2_ctx, d3_ctx, d4_ctx;
  bcpc_pkg::ctx_t c1, c2, c3;
  logic [31:0]    nblk1, dvd2, dvd3, nblk2;
  logic [16:0]    dist_w;

  logic           f1_vld_q, out_vld_q;
  bcpc_pkg::ctx_t f1_ctx_q;
  logic [31:0]    f1_b_q, f1_c_q;
  logic           f1_sel_q;
  logic [31:0]    res;
  logic [30:0]    cnt_d, cnt_q;

  // The whole back end moves together whenever the output slot can take an item.
  assign en          = !out_vld_q || out_ready_i;
  assign item_pop_o  = en;

  // my_process modulo process_count.
  bcpc_div u_div_me (
    .clk_i, .rst_ni, .en_i(en), .valid_i(item_valid_i),
    .dividend_i(32'(cfg_i.me)), .divisor_i(cfg_i.np), .ctx_i(item_i),
    .valid_o(d0_vld), .quot_o(d0_q), .rem_o(d0_r), .ctx_o(d0_ctx)
  );

  always_comb begin
    c1    = d0_ctx;
    c1.me = d0_r;
  end

  // Whole blocks passed before the start index.
  bcpc_div u_div_past (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d0_vld),
    .dividend_i({1'b0, c1.past}), .divisor_i(cfg_i.nb), .ctx_i(c1),
    .valid_o(d1_vld), .quot_o(d1_q), .rem_o(d1_r), .ctx_o(d1_ctx)
  );

  always_comb begin
    c2    = d1_ctx;
    nblk1 = d1_ctx.ge ? d1_q + 32'd1 : 32'd0;
    if (d1_ctx.ge) begin
      c2.inb = 32'(nblk1 * cfg_i.nb) - {1'b0, d1_ctx.past};
    end else begin
      c2.inb = 32'(cfg_i.inb) - {1'b0, d1_ctx.idx};
    end
    dvd2 = 32'(cfg_i.src) + nblk1;
  end

  // Owner of the start index.
  bcpc_div u_div_own (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1_vld),
    .dividend_i(dvd2), .divisor_i(cfg_i.np), .ctx_i(c2),
    .valid_o(d2_vld), .quot_o(d2_q), .rem_o(d2_r), .ctx_o(d2_ctx)
  );

  always_comb begin
    c3       = d2_ctx;
    c3.src   = d2_r;
    c3.zero  = d2_ctx.zero || (d2_ctx.me == d2_r);
    c3.early = {1'b0, d2_ctx.n} <= d2_ctx.inb;
    if (d2_ctx.me >= d2_r) begin
      dist_w = {1'b0, d2_ctx.me} - {1'b0, d2_r};
    end else begin
      dist_w = {1'b0, d2_ctx.me} + {1'b0, cfg_i.np} - {1'b0, d2_r};
    end
    c3.hops = dist_w[15:0];
    dvd3    = {1'b0, d2_ctx.n} - d2_ctx.inb;
  end

  // Blocks touched by the run after its first block.
  bcpc_div u_div_run (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d2_vld),
    .dividend_i(dvd3), .divisor_i(cfg_i.nb), .ctx_i(c3),
    .valid_o(d3_vld), .quot_o(d3_q), .rem_o(d3_r), .ctx_o(d3_ctx)
  );

  assign nblk2 = d3_q + 32'd1;

  // Full rounds of the ring and the blocks left over.
  bcpc_div u_div_ring (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d3_vld),
    .dividend_i(nblk2), .divisor_i(cfg_i.np), .ctx_i(d3_ctx),
    .valid_o(d4_vld), .quot_o(d4_q), .rem_o(d4_r), .ctx_o(d4_ctx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q  <= d4_vld;
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_ctx_q <= d4_ctx;
      f1_b_q   <= 32'((d4_q + 32'd1) * cfg_i.nb);
      f1_c_q   <= 32'(d4_q * cfg_i.nb);
      f1_sel_q <= d4_ctx.hops <= d4_r;
      cnt_q    <= cnt_d;
    end
  end

  always_comb begin
    if (f1_sel_q) begin
      res = f1_ctx_q.inb + 32'(f1_b_q * f1_ctx_q.hops) - 32'(cfg_i.nb);
    end else begin
      res = {1'b0, f1_ctx_q.n} - 32'(f1_c_q * 16'(cfg_i.np - f1_ctx_q.hops));
    end
    if (f1_ctx_q.zero) begin
      cnt_d = '0;
    end else if (f1_ctx_q.early) begin
      cnt_d = f1_ctx_q.n & bcpc_pkg::ResultMask;
    end else begin
      cnt_d = res[30:0] & bcpc_pkg::ResultMask;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign preceding_count_o = cnt_q;

endmodule

// ===== rtl/block_cyclic_preceding_count.sv =====
// Block-cyclic preceding count: top level with configuration registers.
//
// Takes one item per clock cycle at full rate while the output is not stalled. Each
// item passes a two-entry input queue and then five chained dividers of 33
// register stages each (an input register and one stage per quotient bit) and
// two final arithmetic stages. The user must write configuration over the APB
// port only while no item is in flight; the block itself does not enforce this.
// The results follow the registers in effect at that time.
module block_cyclic_preceding_count (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] run_length_i,
  input  logic [30:0] start_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] preceding_count_o
);

  logic [15:0]    fbs_q, nb_q, np_q, me_q;
  logic [16:0]    src_q;
  logic [2:0]     reg_idx;
  logic           wr_en;
  bcpc_pkg::cfg_t cfg;
  logic           item_valid, item_pop;
  bcpc_pkg::ctx_t item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbs_q <= 16'd1;
      nb_q  <= 16'd1;
      np_q  <= 16'd1;
      src_q <= '0;
      me_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        bcpc_pkg::RegFirstBlock: fbs_q <= pwdata[15:0];
        bcpc_pkg::RegBlock:      nb_q  <= pwdata[15:0];
        bcpc_pkg::RegProcCount:  np_q  <= pwdata[15:0];
        bcpc_pkg::RegSource:     src_q <= pwdata[16:0];
        bcpc_pkg::RegMyProc:     me_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bcpc_pkg::RegFirstBlock: prdata = 32'(fbs_q);
      bcpc_pkg::RegBlock:      prdata = 32'(nb_q);
      bcpc_pkg::RegProcCount:  prdata = 32'(np_q);
      bcpc_pkg::RegSource:     prdata = 32'(src_q);
      bcpc_pkg::RegMyProc:     prdata = 32'(me_q);
      default:                 prdata = '0;
    endcase
  end

  // Sizes of zero behave as one.
  always_comb begin
    cfg.inb = (fbs_q == '0) ? 16'd1 : fbs_q;
    cfg.nb  = (nb_q == '0) ? 16'd1 : nb_q;
    cfg.np  = (np_q == '0) ? 16'd1 : np_q;
    cfg.src = src_q[15:0];
    cfg.me  = me_q;
    cfg.rep = src_q[16];
  end

  bcpc_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i, .in_ready_o, .run_length_i, .start_index_i,
    .item_valid_o(item_valid), .item_pop_i(item_pop), .item_o(item)
  );

  bcpc_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .item_valid_i(item_valid), .item_pop_o(item_pop), .item_i(item),
    .out_valid_o, .out_ready_i, .preceding_count_o
  );

endmodule
